// File: sv/fbc_pkg.sv
package fbc_pkg;

  localparam int VALUE_W      = 32;
  localparam int MODE_W       = 2;
  localparam int SLOT_W       = 3;
  localparam int INDEX_W      = 3;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 4;
  localparam int PCOUNT_W     = 4;
  localparam int CORNER_COUNT = 8;
  localparam int CIDX_W       = 3;
  localparam int CCNT_W       = CIDX_W + 1;
  localparam int AXES         = 3;
  localparam int COEFS        = 4;
  localparam int VALUES       = 6;
  localparam int D_SHIFT      = 16;

  localparam logic [INDEX_W-1:0]   FACE_LAST        = 3'd5;
  localparam logic [PCOUNT_W-1:0]  PLANE_COUNT_RST  = 4'd6;
  localparam logic                 CORNER_EN_RST    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_EN    = 1'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_PLANE  = 2'd0,
    MODE_LOAD_CORNER = 2'd1,
    MODE_TEST_BOX    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REASON_NONE  = 2'd0,
    REASON_PLANE = 2'd1,
    REASON_FACE  = 2'd2
  } reason_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLANE,
    ST_CORNER,
    ST_FACE,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    PSTEP_READ,
    PSTEP_X,
    PSTEP_Y,
    PSTEP_Z,
    PSTEP_SUM
  } plane_step_e;

  typedef struct packed {
    logic [CIDX_W-1:0]  rd_addr;
    logic               take;
    logic               first;
    logic [INDEX_W-1:0] face;
  } corner_ctl_t;

endpackage

// File: sv/fbc_if.sv
interface fbc_in_if;
  import fbc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic [SLOT_W-1:0]          slot;
  logic signed [VALUE_W-1:0]  value_0;
  logic signed [VALUE_W-1:0]  value_1;
  logic signed [VALUE_W-1:0]  value_2;
  logic signed [VALUE_W-1:0]  value_3;
  logic signed [VALUE_W-1:0]  value_4;
  logic signed [VALUE_W-1:0]  value_5;

  modport source (
    output valid, mode, slot, value_0, value_1, value_2, value_3, value_4, value_5,
    input  ready
  );

  modport sink (
    input  valid, mode, slot, value_0, value_1, value_2, value_3, value_4, value_5,
    output ready
  );
endinterface

interface fbc_out_if;
  import fbc_pkg::*;

  logic               valid;
  logic               ready;
  logic               visible;
  logic [1:0]         reject_reason;
  logic [INDEX_W-1:0] reject_index;

  modport source (
    output valid, visible, reject_reason, reject_index,
    input  ready
  );

  modport sink (
    input  valid, visible, reject_reason, reject_index,
    output ready
  );
endinterface

// File: sv/fbc_plane_mac.sv
module fbc_plane_mac #(
  parameter int MAX_PLANES = 8,
  parameter int EFF_W      = 32,
  parameter int PIDX_W     = 3
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [PIDX_W-1:0]            wr_addr_i,
  input  logic signed [EFF_W-1:0]      wr_coef_i [fbc_pkg::COEFS],
  input  logic [PIDX_W-1:0]            rd_addr_i,
  input  fbc_pkg::plane_step_e         step_i,
  input  logic signed [EFF_W-1:0]      box_min_i [fbc_pkg::AXES],
  input  logic signed [EFF_W-1:0]      box_max_i [fbc_pkg::AXES],
  output logic                         neg_o
);
  import fbc_pkg::*;

  localparam int ROW_W  = COEFS * EFF_W;
  localparam int PROD_W = 2 * EFF_W;
  localparam int ACC_W  = 2 * EFF_W + 2;

  logic [ROW_W-1:0]          mem_q [MAX_PLANES];
  logic [ROW_W-1:0]          rd_q;
  logic signed [EFF_W-1:0]   coef [COEFS];
  logic [1:0]                axis;
  logic                      swap;
  logic signed [EFF_W-1:0]   mul_a;
  logic signed [EFF_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [ACC_W-1:0]   d_term;
  logic signed [ACC_W-1:0]   sum;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_coef_i[3], wr_coef_i[2], wr_coef_i[1], wr_coef_i[0]};
    end
    rd_q <= mem_q[rd_addr_i];
  end

  always_comb begin
    for (int k = 0; k < COEFS; k++) begin
      coef[k] = rd_q[k*EFF_W +: EFF_W];
    end
  end

  always_comb begin
    case (step_i)
      PSTEP_Y: axis = 2'd1;
      PSTEP_Z: axis = 2'd2;
      default: axis = 2'd0;
    endcase
  end

  // pick the box corner that maximizes the plane value on this axis
  assign swap   = box_min_i[axis] > box_max_i[axis];
  assign mul_a  = coef[axis];
  assign mul_b  = (mul_a[EFF_W-1] ^ swap) ? box_min_i[axis] : box_max_i[axis];
  assign prod_d = mul_a * mul_b;
  assign d_term = ACC_W'(coef[3]) <<< D_SHIFT;
  assign sum    = acc_q + ACC_W'(prod_q);
  assign neg_o  = sum[ACC_W-1];

  always_ff @(posedge clk_i) begin
    case (step_i)
      PSTEP_X: begin
        prod_q <= prod_d;
        acc_q  <= d_term;
      end
      PSTEP_Y, PSTEP_Z: begin
        prod_q <= prod_d;
        acc_q  <= sum;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/fbc_corner_scan.sv
module fbc_corner_scan #(
  parameter int EFF_W = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [fbc_pkg::CIDX_W-1:0] wr_addr_i,
  input  logic signed [EFF_W-1:0]  wr_coord_i [fbc_pkg::AXES],
  input  fbc_pkg::corner_ctl_t     ctl_i,
  input  logic signed [EFF_W-1:0]  box_min_i [fbc_pkg::AXES],
  input  logic signed [EFF_W-1:0]  box_max_i [fbc_pkg::AXES],
  output logic                     beyond_o
);
  import fbc_pkg::*;

  localparam int ROW_W = AXES * EFF_W;

  logic [ROW_W-1:0]         mem_q [CORNER_COUNT];
  logic [ROW_W-1:0]         rd_q;
  logic signed [EFF_W-1:0]  q [AXES];
  logic signed [EFF_W-1:0]  min_q [AXES];
  logic signed [EFF_W-1:0]  max_q [AXES];
  logic [1:0]               axis;
  logic signed [EFF_W-1:0]  lo_sel;
  logic signed [EFF_W-1:0]  hi_sel;
  logic signed [EFF_W-1:0]  bmin_sel;
  logic signed [EFF_W-1:0]  bmax_sel;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_coord_i[2], wr_coord_i[1], wr_coord_i[0]};
    end
    rd_q <= mem_q[ctl_i.rd_addr];
  end

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      q[k] = rd_q[k*EFF_W +: EFF_W];
    end
  end

  // running bounds of the frustum corners per axis
  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      for (int k = 0; k < AXES; k++) begin
        if (ctl_i.first || q[k] < min_q[k]) begin
          min_q[k] <= q[k];
        end
        if (ctl_i.first || q[k] > max_q[k]) begin
          max_q[k] <= q[k];
        end
      end
    end
  end

  always_comb begin
    case (ctl_i.face[2:1])
      2'd1:    axis = 2'd1;
      2'd2:    axis = 2'd2;
      default: axis = 2'd0;
    endcase
  end

  assign lo_sel   = min_q[axis];
  assign hi_sel   = max_q[axis];
  assign bmin_sel = box_min_i[axis];
  assign bmax_sel = box_max_i[axis];

  // even faces are the max side, odd faces the min side
  assign beyond_o = ctl_i.face[0] ? (hi_sel < bmin_sel) : (lo_sel > bmax_sel);

endmodule

// File: sv/frustum_box_cull_test.sv
// Frustum versus axis-aligned box cull test. Load words (mode 0 plane a,b,c,d; mode 1 frustum
// corner x,y,z) are taken whenever the block is idle. A test word (mode 2) occupies the block
// for plane work on P planes, P being the planes tried before a rejection or plane_count
// saturated to MAX_PLANES, then, with the corner check on, a corner scan and 1 to 6 face
// checks, and a done step when the box survives. The plane work uses the single shared
// multiplier: one registered plane row read, three products per plane choosing the box corner
// that maximizes the plane value, then a sign check of the exact sum. The corner scan reads
// the eight corners one per cycle from the corner memory. The result word sits in an output
// register, so load words are taken while it waits.
module frustum_box_cull_test #(
  parameter int MAX_PLANES  = 8,
  parameter int COORD_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  fbc_in_if.sink                             in_i,
  fbc_out_if.source                          out_o,
  input  logic                               cfg_we_i,
  input  logic [fbc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fbc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import fbc_pkg::*;

  localparam int EFF_W  = (COORD_WIDTH < VALUE_W) ? COORD_WIDTH : VALUE_W;
  localparam int PIDX_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int PCNT_W = $clog2(MAX_PLANES + 1);

  state_e                   state_q, state_d;
  plane_step_e              pstep_q, pstep_d;
  logic [PCNT_W-1:0]        plane_idx_q, plane_idx_d;
  logic [PCNT_W-1:0]        plane_n_q, plane_n_d;
  logic [PCNT_W-1:0]        n_sat;
  logic [CCNT_W-1:0]        ccnt_q, ccnt_d;
  logic [INDEX_W-1:0]       face_q, face_d;
  logic [PCOUNT_W-1:0]      plane_count_q;
  logic                     corner_en_q;

  logic signed [EFF_W-1:0]  in_val [VALUES];
  logic signed [EFF_W-1:0]  plane_wr [COEFS];
  logic signed [EFF_W-1:0]  corner_wr [AXES];
  logic signed [EFF_W-1:0]  box_min_q [AXES];
  logic signed [EFF_W-1:0]  box_max_q [AXES];

  logic                     in_acc;
  logic                     is_test;
  logic                     plane_we;
  logic                     corner_we;
  logic                     plane_neg;
  logic                     last_plane;
  logic                     beyond;
  corner_ctl_t              cctl;

  logic                     out_free;
  logic                     fin;
  logic                     fire;
  logic                     res_visible;
  reason_e                  res_reason;
  logic [INDEX_W-1:0]       res_index;
  logic                     out_valid_q;
  logic                     out_visible_q;
  reason_e                  out_reason_q;
  logic [INDEX_W-1:0]       out_index_q;

  assign in_val[0] = in_i.value_0[EFF_W-1:0];
  assign in_val[1] = in_i.value_1[EFF_W-1:0];
  assign in_val[2] = in_i.value_2[EFF_W-1:0];
  assign in_val[3] = in_i.value_3[EFF_W-1:0];
  assign in_val[4] = in_i.value_4[EFF_W-1:0];
  assign in_val[5] = in_i.value_5[EFF_W-1:0];

  always_comb begin
    for (int k = 0; k < COEFS; k++) begin
      plane_wr[k] = in_val[k];
    end
    for (int k = 0; k < AXES; k++) begin
      corner_wr[k] = in_val[k];
    end
  end

  assign in_acc    = in_i.valid && in_i.ready;
  assign is_test   = mode_e'(in_i.mode) == MODE_TEST_BOX;
  assign plane_we  = in_acc && (mode_e'(in_i.mode) == MODE_LOAD_PLANE)
                     && (int'(in_i.slot) < MAX_PLANES);
  assign corner_we = in_acc && (mode_e'(in_i.mode) == MODE_LOAD_CORNER);

  assign n_sat      = (int'(plane_count_q) > MAX_PLANES) ? PCNT_W'(MAX_PLANES)
                                                         : PCNT_W'(plane_count_q);
  assign last_plane = plane_idx_q == (plane_n_q - 1'b1);
  assign out_free   = !out_valid_q || out_o.ready;
  assign fire       = fin && out_free;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_count_q <= PLANE_COUNT_RST;
      corner_en_q   <= CORNER_EN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PLANE_COUNT: plane_count_q <= cfg_data_i[PCOUNT_W-1:0];
        CFG_CORNER_EN:   corner_en_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && is_test) begin
          if (n_sat != '0) begin
            state_d = ST_PLANE;
          end else begin
            state_d = corner_en_q ? ST_CORNER : ST_DONE;
          end
        end
      end
      ST_PLANE: begin
        if (pstep_q == PSTEP_SUM) begin
          if (plane_neg) begin
            if (out_free) begin
              state_d = ST_IDLE;
            end
          end else if (last_plane) begin
            state_d = corner_en_q ? ST_CORNER : ST_DONE;
          end
        end
      end
      ST_CORNER: begin
        if (ccnt_q == CCNT_W'(CORNER_COUNT)) begin
          state_d = ST_FACE;
        end
      end
      ST_FACE: begin
        if (beyond) begin
          if (out_free) begin
            state_d = ST_IDLE;
          end
        end else if (face_q == FACE_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_i.ready   = 1'b0;
    pstep_d      = PSTEP_READ;
    plane_idx_d  = plane_idx_q;
    plane_n_d    = plane_n_q;
    ccnt_d       = '0;
    face_d       = '0;
    cctl.rd_addr = ccnt_q[CIDX_W-1:0];
    cctl.take    = 1'b0;
    cctl.first   = 1'b0;
    cctl.face    = face_q;
    fin          = 1'b0;
    res_visible  = 1'b1;
    res_reason   = REASON_NONE;
    res_index    = '0;
    case (state_q)
      ST_IDLE: begin
        in_i.ready  = 1'b1;
        plane_idx_d = '0;
        plane_n_d   = n_sat;
      end
      ST_PLANE: begin
        case (pstep_q)
          PSTEP_READ: pstep_d = PSTEP_X;
          PSTEP_X:    pstep_d = PSTEP_Y;
          PSTEP_Y:    pstep_d = PSTEP_Z;
          PSTEP_Z:    pstep_d = PSTEP_SUM;
          default: begin
            pstep_d = PSTEP_SUM;
            if (plane_neg) begin
              fin         = 1'b1;
              res_visible = 1'b0;
              res_reason  = REASON_PLANE;
              res_index   = INDEX_W'(plane_idx_q);
            end else if (!last_plane) begin
              plane_idx_d = plane_idx_q + 1'b1;
              pstep_d     = PSTEP_READ;
            end
          end
        endcase
      end
      ST_CORNER: begin
        ccnt_d     = (ccnt_q == CCNT_W'(CORNER_COUNT)) ? ccnt_q : ccnt_q + 1'b1;
        cctl.take  = ccnt_q != '0;
        cctl.first = ccnt_q == CCNT_W'(1);
      end
      ST_FACE: begin
        face_d = face_q;
        if (beyond) begin
          fin         = 1'b1;
          res_visible = 1'b0;
          res_reason  = REASON_FACE;
          res_index   = face_q;
        end else if (face_q != FACE_LAST) begin
          face_d = face_q + 1'b1;
        end
      end
      ST_DONE: begin
        fin = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pstep_q     <= PSTEP_READ;
      plane_idx_q <= '0;
      plane_n_q   <= '0;
      ccnt_q      <= '0;
      face_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pstep_q     <= pstep_d;
      plane_idx_q <= plane_idx_d;
      plane_n_q   <= plane_n_d;
      ccnt_q      <= ccnt_d;
      face_q      <= face_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_test) begin
      for (int k = 0; k < AXES; k++) begin
        box_min_q[k] <= in_val[k];
        box_max_q[k] <= in_val[AXES + k];
      end
    end
    if (fire) begin
      out_visible_q <= res_visible;
      out_reason_q  <= res_reason;
      out_index_q   <= res_index;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.visible       = out_visible_q;
  assign out_o.reject_reason = out_reason_q;
  assign out_o.reject_index  = out_index_q;

  fbc_plane_mac #(
    .MAX_PLANES (MAX_PLANES),
    .EFF_W      (EFF_W),
    .PIDX_W     (PIDX_W)
  ) u_plane_mac (
    .clk_i     (clk_i),
    .wr_en_i   (plane_we),
    .wr_addr_i (PIDX_W'(in_i.slot)),
    .wr_coef_i (plane_wr),
    .rd_addr_i (plane_idx_q[PIDX_W-1:0]),
    .step_i    (pstep_q),
    .box_min_i (box_min_q),
    .box_max_i (box_max_q),
    .neg_o     (plane_neg)
  );

  fbc_corner_scan #(
    .EFF_W (EFF_W)
  ) u_corner_scan (
    .clk_i      (clk_i),
    .wr_en_i    (corner_we),
    .wr_addr_i  (in_i.slot),
    .wr_coord_i (corner_wr),
    .ctl_i      (cctl),
    .box_min_i  (box_min_q),
    .box_max_i  (box_max_q),
    .beyond_o   (beyond)
  );

endmodule

// File: verif/frustum_cull_checker.sv
`timescale 1ns / 1ps

module frustum_cull_checker #(
  parameter int MAX_PLANES = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  fbc_in_if                              box_i,
  fbc_out_if                             cull_i,
  input  logic                           cfg_we_i,
  input  logic [fbc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fbc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             errors_o,
  output int                             pending_o
);
  import fbc_pkg::*;

  localparam int BOX_CORNERS = 8;
  localparam int ACC_W       = 72;

  typedef struct packed {
    logic               visible;
    reason_e            reason;
    logic [INDEX_W-1:0] index;
  } cull_word_t;

  logic signed [VALUE_W-1:0] plane_coef [MAX_PLANES][COEFS];
  logic signed [VALUE_W-1:0] frustum_pt [CORNER_COUNT][AXES];
  logic [PCOUNT_W-1:0]       plane_count;
  logic                      corner_check_on;
  cull_word_t                awaited_q [$];
  cull_word_t                head;
  int                        errors;
  int                        words_seen;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] word %0d: %s: got %0d, expected %0d", $time, words_seen, what, got, want);
    errors++;
  endtask

  // exact sign of a*x + b*y + c*z + d*2^16
  function automatic logic below_plane(input int p, input logic signed [VALUE_W-1:0] x,
                                       input logic signed [VALUE_W-1:0] y,
                                       input logic signed [VALUE_W-1:0] z);
    logic signed [ACC_W-1:0] wa, wb, wc, wd, acc;
    wa = plane_coef[p][0];
    wb = plane_coef[p][1];
    wc = plane_coef[p][2];
    wd = plane_coef[p][3];
    acc = wa * x + wb * y + wc * z + (wd <<< D_SHIFT);
    return acc[ACC_W-1];
  endfunction

  function automatic cull_word_t predict_cull(input logic [VALUES-1:0][VALUE_W-1:0] box);
    cull_word_t                res;
    int                        n;
    int                        axis;
    int                        beyond;
    logic                      all_out;
    logic signed [VALUE_W-1:0] px, py, pz, lim, q;
    res = '{visible: 1'b1, reason: REASON_NONE, index: '0};
    n = (plane_count > MAX_PLANES) ? MAX_PLANES : int'(plane_count);
    for (int i = 0; i < n; i++) begin
      all_out = 1'b1;
      for (int c = 0; c < BOX_CORNERS; c++) begin
        px = c[0] ? box[3] : box[0];
        py = c[1] ? box[4] : box[1];
        pz = c[2] ? box[5] : box[2];
        if (!below_plane(i, px, py, pz)) all_out = 1'b0;
      end
      if (all_out) begin
        return '{visible: 1'b0, reason: REASON_PLANE, index: INDEX_W'(i)};
      end
    end
    if (corner_check_on) begin
      // faces in order +x, -x, +y, -y, +z, -z
      for (int f = 0; f <= int'(FACE_LAST); f++) begin
        axis = f >> 1;
        lim = f[0] ? box[axis] : box[AXES + axis];
        beyond = 0;
        for (int p = 0; p < CORNER_COUNT; p++) begin
          q = frustum_pt[p][axis];
          if (f[0] ? (q < lim) : (q > lim)) beyond++;
        end
        if (beyond == CORNER_COUNT) begin
          return '{visible: 1'b0, reason: REASON_FACE, index: INDEX_W'(f)};
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_count = PLANE_COUNT_RST;
      corner_check_on = CORNER_EN_RST;
      awaited_q.delete();
      errors = 0;
      words_seen = 0;
    end else begin
      if (cull_i.valid && cull_i.ready) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("result word with nothing awaited", int'(cull_i.visible), -1);
        end else begin
          head = awaited_q.pop_front();
          if (cull_i.visible !== head.visible)
            report_mismatch("visible", int'(cull_i.visible), int'(head.visible));
          if (cull_i.reject_reason !== head.reason)
            report_mismatch("reject_reason", int'(cull_i.reject_reason), int'(head.reason));
          if (cull_i.reject_index !== head.index)
            report_mismatch("reject_index", int'(cull_i.reject_index), int'(head.index));
        end
        words_seen++;
      end
      if (box_i.valid && box_i.ready) begin
        case (mode_e'(box_i.mode))
          MODE_LOAD_PLANE: begin
            plane_coef[box_i.slot][0] = box_i.value_0;
            plane_coef[box_i.slot][1] = box_i.value_1;
            plane_coef[box_i.slot][2] = box_i.value_2;
            plane_coef[box_i.slot][3] = box_i.value_3;
          end
          MODE_LOAD_CORNER: begin
            frustum_pt[box_i.slot][0] = box_i.value_0;
            frustum_pt[box_i.slot][1] = box_i.value_1;
            frustum_pt[box_i.slot][2] = box_i.value_2;
          end
          MODE_TEST_BOX: begin
            awaited_q.push_back(predict_cull({box_i.value_5, box_i.value_4, box_i.value_3,
                                              box_i.value_2, box_i.value_1, box_i.value_0}));
          end
          default: ;
        endcase
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_PLANE_COUNT) plane_count = cfg_data_i;
        else if (cfg_index_i == CFG_CORNER_EN) corner_check_on = cfg_data_i[0];
      end
    end
    errors_o = errors;
    pending_o = awaited_q.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fbc_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 4;
  localparam int PLANE_SLOTS   = 8;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 100;
  localparam int DRAIN_PAUSE   = 64;
  localparam int IDLE_LIMIT    = 4000;
  localparam int MAX_GAP       = 24;
  localparam int MAX_BURST     = 20;

  localparam logic [MODE_W-1:0]   MODE_RESERVED = 2'd3;
  localparam logic [PCOUNT_W-1:0] NO_PLANES     = 4'd0;
  localparam logic [PCOUNT_W-1:0] ALL_PLANES    = 4'd8;

  localparam logic signed [VALUE_W-1:0] ONE  = 32'sd65536;
  localparam logic signed [VALUE_W-1:0] SPAN = 32'sd6553600;
  localparam logic signed [VALUE_W-1:0] HALF = 32'sd3276800;
  localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7fff_ffff;

  localparam logic [PCOUNT_W-1:0] PHASE_COUNT [RAND_PHASES] =
    '{4'd8, 4'd15, 4'd0, 4'd6, 4'd1, 4'd9, 4'd3, 4'd8};
  localparam logic PHASE_CORNER_ON [RAND_PHASES] =
    '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

  typedef enum int {RDY_FREE, RDY_COIN, RDY_BURSTS, RDY_SPARSE} stall_style_e;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    fails;
  int                    awaited;
  int                    burst_left  = 0;
  logic                  gaps_on     = 1'b1;
  int                    idle_cycles = 0;
  stall_style_e          stall_style = RDY_FREE;
  int                    style_left  = 0;
  int                    stall_left  = 0;

  fbc_in_if  box_if ();
  fbc_out_if cull_if ();

  frustum_box_cull_test #(
    .MAX_PLANES (PLANE_SLOTS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (box_if),
    .out_o       (cull_if),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  frustum_cull_checker #(
    .MAX_PLANES (PLANE_SLOTS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .box_i       (box_if),
    .cull_i      (cull_if),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (fails),
    .pending_o   (awaited)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // result side backpressure
  always @(negedge clk_i) begin
    logic rdy;
    if (style_left == 0) begin
      stall_style = stall_style_e'($urandom_range(0, 3));
      style_left = $urandom_range(50, 300);
    end
    style_left--;
    if (stall_left > 0) begin
      rdy = 1'b0;
      stall_left--;
    end else begin
      case (stall_style)
        RDY_FREE: rdy = 1'b1;
        RDY_COIN: rdy = 1'($urandom_range(0, 1));
        RDY_BURSTS: begin
          if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(5, 40);
            rdy = 1'b0;
          end else begin
            rdy = 1'b1;
          end
        end
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
    end
    cull_if.ready = rdy;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((box_if.valid && box_if.ready) || (cull_if.valid && cull_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                           input logic signed [VALUE_W-1:0] v0, v1, v2, v3, v4, v5);
    int gap;
    if (burst_left == 0) begin
      gap = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, MAX_GAP) : 0;
      if (gap > 0) begin
        box_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, MAX_BURST);
    end
    box_if.valid   = 1'b1;
    box_if.mode    = mode;
    box_if.slot    = slot;
    box_if.value_0 = v0;
    box_if.value_1 = v1;
    box_if.value_2 = v2;
    box_if.value_3 = v3;
    box_if.value_4 = v4;
    box_if.value_5 = v5;
    @(posedge clk_i);
    while (!box_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic send_plane(input logic [SLOT_W-1:0] slot,
                            input logic signed [VALUE_W-1:0] a, b, c, d);
    send_word(MODE_LOAD_PLANE, slot, a, b, c, d, $urandom, $urandom);
  endtask

  task automatic send_corner(input logic [SLOT_W-1:0] slot,
                             input logic signed [VALUE_W-1:0] x, y, z);
    send_word(MODE_LOAD_CORNER, slot, x, y, z, $urandom, $urandom, $urandom);
  endtask

  task automatic send_box(input logic signed [VALUE_W-1:0] x0, y0, z0, x1, y1, z1);
    send_word(MODE_TEST_BOX, SLOT_W'($urandom), x0, y0, z0, x1, y1, z1);
  endtask

  task automatic send_junk();
    send_word(MODE_RESERVED, SLOT_W'($urandom), $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom);
  endtask

  // registers change only once every result is in and the block has settled
  task automatic set_config(input logic [PCOUNT_W-1:0] count, input logic en);
    box_if.valid = 1'b0;
    while (awaited != 0) @(negedge clk_i);
    repeat (DRAIN_PAUSE) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_index = CFG_PLANE_COUNT;
    cfg_data  = count;
    @(negedge clk_i);
    cfg_index = CFG_CORNER_EN;
    cfg_data  = {(CFG_DATA_W-1)'($urandom), en};
    @(negedge clk_i);
    cfg_we     = 1'b0;
    burst_left = 0;
  endtask

  function automatic logic signed [VALUE_W-1:0] near(input int center, input int spread);
    int off;
    off = int'($urandom_range(0, 2 * spread)) - spread;
    return VALUE_W'(center + off);
  endfunction

  function automatic logic signed [VALUE_W-1:0] noisy(input logic signed [VALUE_W-1:0] v);
    return ($urandom_range(0, 15) == 0) ? VALUE_W'($urandom) : v;
  endfunction

  task automatic rand_plane(input logic [SLOT_W-1:0] slot);
    send_plane(slot, noisy(near(0, ONE)), noisy(near(0, ONE)), noisy(near(0, ONE)),
               noisy(near(HALF, 3 * HALF)));
  endtask

  task automatic rand_corner(input logic [SLOT_W-1:0] slot, input int cx, cy, cz);
    send_corner(slot, noisy(near(cx, SPAN / 4)), noisy(near(cy, SPAN / 4)),
                noisy(near(cz, SPAN / 4)));
  endtask

  // full plane set plus a clustered set of frustum corners
  task automatic rand_frustum();
    int cx, cy, cz;
    cx = near(0, SPAN);
    cy = near(0, SPAN);
    cz = near(0, SPAN);
    for (int p = 0; p < PLANE_SLOTS; p++) rand_plane(SLOT_W'(p));
    for (int c = 0; c < CORNER_COUNT; c++) rand_corner(SLOT_W'(c), cx, cy, cz);
  endtask

  task automatic rand_box();
    logic signed [VALUE_W-1:0] lo [AXES];
    logic signed [VALUE_W-1:0] hi [AXES];
    logic signed [VALUE_W-1:0] cen, ext;
    for (int a = 0; a < AXES; a++) begin
      cen = near(0, SPAN);
      ext = VALUE_W'($urandom_range(0, SPAN / 4));
      lo[a] = noisy(cen - ext);
      hi[a] = noisy(cen + ext);
      if ($urandom_range(0, 9) == 0) begin
        cen = lo[a];
        lo[a] = hi[a];
        hi[a] = cen;
      end
    end
    send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  // box lying wholly outside one of the axis-aligned planes
  task automatic plane_box(input int p);
    logic signed [VALUE_W-1:0] lo [AXES];
    logic signed [VALUE_W-1:0] hi [AXES];
    for (int a = 0; a < AXES; a++) begin
      lo[a] = -ONE;
      hi[a] = ONE;
    end
    if (p[0]) begin
      lo[p >> 1] = SPAN + ONE;
      hi[p >> 1] = 2 * SPAN;
    end else begin
      lo[p >> 1] = -2 * SPAN;
      hi[p >> 1] = -SPAN - ONE;
    end
    send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  // box with every frustum corner beyond one face
  task automatic face_box(input int f);
    logic signed [VALUE_W-1:0] lo [AXES];
    logic signed [VALUE_W-1:0] hi [AXES];
    for (int a = 0; a < AXES; a++) begin
      lo[a] = -SPAN;
      hi[a] = SPAN;
    end
    if (f[0]) lo[f >> 1] = HALF + ONE;
    else hi[f >> 1] = -HALF - ONE;
    send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  initial begin
    logic signed [VALUE_W-1:0] sgn;
    int counted;
    int pick;
    box_if.valid   = 1'b0;
    box_if.mode    = '0;
    box_if.slot    = '0;
    box_if.value_0 = '0;
    box_if.value_1 = '0;
    box_if.value_2 = '0;
    box_if.value_3 = '0;
    box_if.value_4 = '0;
    box_if.value_5 = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // nothing loaded yet: with no planes and no corner test every box passes
    set_config(NO_PLANES, 1'b0);
    send_box(VMIN, VMIN, VMIN, VMAX, VMAX, VMAX);

    for (int p = 0; p < 6; p++) begin
      sgn = p[0] ? -ONE : ONE;
      send_plane(SLOT_W'(p), (p >> 1) == 0 ? sgn : '0, (p >> 1) == 1 ? sgn : '0,
                 (p >> 1) == 2 ? sgn : '0, SPAN);
    end
    send_plane(3'd6, VMIN, VMIN, VMIN, VMIN);
    send_plane(3'd7, VMAX, VMAX, VMAX, VMAX);
    for (int c = 0; c < CORNER_COUNT; c++) begin
      send_corner(SLOT_W'(c), c[0] ? HALF : -HALF, c[1] ? HALF : -HALF, c[2] ? HALF : -HALF);
    end
    send_junk();

    set_config(ALL_PLANES, 1'b1);
    plane_box(0);
    plane_box(5);
    send_box(ONE, ONE, ONE, HALF, HALF, HALF);
    send_box(-HALF, -HALF, -HALF, -ONE, -ONE, -ONE);
    face_box(0);
    face_box(5);
    // corners exactly on the face are not beyond it
    send_box(-SPAN, -SPAN, -SPAN, -HALF, SPAN, SPAN);
    // min above max
    send_box(ONE, ONE, ONE, -ONE, -ONE, -ONE);
    send_box(VMIN, VMIN, VMIN, VMAX, VMAX, VMAX);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_config(PHASE_COUNT[ph], PHASE_CORNER_ON[ph]);
      gaps_on = (ph % 3 != 1);
      counted = 0;
      if ($urandom_range(0, 1) == 1) begin
        rand_frustum();
        counted += PLANE_SLOTS + CORNER_COUNT;
      end
      while (counted < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          rand_plane(SLOT_W'($urandom));
          counted++;
        end else if (pick < 12) begin
          rand_corner(SLOT_W'($urandom), 0, 0, 0);
          counted++;
        end else if (pick < 15) begin
          send_junk();
        end else begin
          rand_box();
          counted++;
        end
      end
    end

    box_if.valid = 1'b0;
    while (awaited != 0) @(negedge clk_i);
    repeat (DRAIN_PAUSE) @(negedge clk_i);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/fbc_pkg.sv
sv/fbc_if.sv
sv/fbc_plane_mac.sv
sv/fbc_corner_scan.sv
sv/frustum_box_cull_test.sv
verif/frustum_cull_checker.sv
verif/tb_top.sv
